### rtl/arp_pkg.sv
// Shared types, constants and helper functions for the ARP reply responder.
// No dependencies; every other file but arp_stream_if imports this package.
package arp_pkg;

    // Header geometry
    localparam int HDR_LEN = 42;
    localparam int POS_W   = 6;
    localparam logic [POS_W-1:0] LAST_IDX = POS_W'(HDR_LEN - 1);
    localparam logic [POS_W-1:0] HDR_END  = POS_W'(HDR_LEN);

    // Frame offsets of the checked fields
    localparam logic [POS_W-1:0] OFS_ETYPE_HI = POS_W'(12);
    localparam logic [POS_W-1:0] OFS_ETYPE_LO = POS_W'(13);
    localparam logic [POS_W-1:0] OFS_TPA_0    = POS_W'(38);
    localparam logic [POS_W-1:0] OFS_TPA_1    = POS_W'(39);
    localparam logic [POS_W-1:0] OFS_TPA_2    = POS_W'(40);
    localparam logic [POS_W-1:0] OFS_TPA_3    = POS_W'(41);

    // EtherTypes answered and the reply opcode byte
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_RARP = 16'h8035;
    localparam logic [7:0]  OPCODE_REPLY_LO = 8'h02;

    // Configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = CFG_IDX_W'(1);
    localparam logic [31:0] OWN_IP_RST  = 32'h0A14_280A;
    localparam logic [47:0] OWN_MAC_RST = 48'h0A14_280A_0A0A;

    typedef logic [POS_W-1:0] t_pos;

    // Header store write request
    typedef struct packed {
        logic       en;
        t_pos       addr;
        logic [7:0] data;
    } t_hdr_wr;

    // Reply sequencer states
    typedef enum logic {
        TX_IDLE,
        TX_SEND
    } t_tx_state;

    // Where one reply byte comes from
    typedef enum logic [2:0] {
        SRC_MEM,
        SRC_MAC,
        SRC_IP,
        SRC_ZERO,
        SRC_OPCODE
    } t_src_kind;

    typedef struct packed {
        t_src_kind kind;
        t_pos      sel;
    } t_src;

    // Map a reply byte index to its source and header address or field byte
    function automatic t_src reply_src(input t_pos idx);
        t_src s;
        s.kind = SRC_MEM;
        s.sel  = idx;
        if (idx < POS_W'(6)) begin
            s.sel = idx + POS_W'(6);
        end else if (idx < POS_W'(12)) begin
            s.kind = SRC_MAC;
            s.sel  = idx - POS_W'(6);
        end else if (idx < POS_W'(20)) begin
            s.sel = idx;
        end else if (idx == POS_W'(20)) begin
            s.kind = SRC_ZERO;
        end else if (idx == POS_W'(21)) begin
            s.kind = SRC_OPCODE;
        end else if (idx < POS_W'(28)) begin
            s.kind = SRC_MAC;
            s.sel  = idx - POS_W'(22);
        end else if (idx < POS_W'(32)) begin
            s.kind = SRC_IP;
            s.sel  = idx - POS_W'(28);
        end else begin
            s.sel = idx - POS_W'(10);
        end
        return s;
    endfunction

    // Byte n of a MAC, most significant first
    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] n);
        logic [7:0] b;
        case (n)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            3'd5:    b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Byte n of an IPv4 address, most significant first
    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] n);
        logic [7:0] b;
        case (n)
            2'd0:    b = ip[31:24];
            2'd1:    b = ip[23:16];
            2'd2:    b = ip[15:8];
            2'd3:    b = ip[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### rtl/arp_stream_if.sv
// Valid/ready stream interfaces for received frame bytes and reply bytes.
// Depends on nothing.
interface arp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, data_byte, frame_end, input ready);
    modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

interface arp_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic       reply_last;

    modport source (output valid, reply_byte, reply_last, input ready);
    modport sink   (input valid, reply_byte, reply_last, output ready);
endinterface

### rtl/arp_hdr_ram.sv
// Header store: 42 x 8 synchronous memory, one write and one registered read port.
// Depends on arp_pkg.
module arp_hdr_ram
    import arp_pkg::*;
(
    input  logic       i_clk,
    input  t_hdr_wr    i_wr,
    input  logic       i_rd_en,
    input  t_pos       i_rd_addr,
    output logic [7:0] o_rd_data
);

    logic [7:0] mem [HDR_LEN];
    logic [7:0] r_rd_data;

    // Write the incoming header byte
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read; hold data when no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/arp_rx.sv
// Receive side: byte position, header store writes and the request match check.
// Depends on arp_pkg and arp_stream_if.
module arp_rx
    import arp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    arp_rx_if.sink      i_rx,
    input  logic        i_busy,
    input  logic [31:0] i_own_ip,
    output t_hdr_wr     o_wr,
    output logic        o_start
);

    t_pos        r_pos, n_pos;
    logic [15:0] r_etype, n_etype;
    logic [31:0] r_tpa, n_tpa;
    logic        accept;
    logic        storing;
    logic        full_frame;
    logic        etype_ok;

    assign i_rx.ready = !i_busy;
    assign accept     = i_rx.valid && i_rx.ready;
    assign storing    = accept && (r_pos < HDR_END);

    // Write the byte into the header store
    always_comb begin
        o_wr.en   = storing;
        o_wr.addr = r_pos;
        o_wr.data = i_rx.data_byte;
    end

    // Advance the position, saturate at the header length, drop at frame end
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_rx.frame_end) begin
                n_pos = '0;
            end else if (r_pos < HDR_END) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    // Capture the EtherType and target IP as they pass
    always_comb begin
        n_etype = r_etype;
        n_tpa   = r_tpa;
        if (storing) begin
            case (r_pos)
                OFS_ETYPE_HI: n_etype[15:8] = i_rx.data_byte;
                OFS_ETYPE_LO: n_etype[7:0]  = i_rx.data_byte;
                OFS_TPA_0:    n_tpa[31:24]  = i_rx.data_byte;
                OFS_TPA_1:    n_tpa[23:16]  = i_rx.data_byte;
                OFS_TPA_2:    n_tpa[15:8]   = i_rx.data_byte;
                OFS_TPA_3:    n_tpa[7:0]    = i_rx.data_byte;
                default:      ;
            endcase
        end
    end

    // Check the request on its last byte
    assign full_frame = accept && i_rx.frame_end && (r_pos >= LAST_IDX);
    assign etype_ok   = (n_etype == ETYPE_ARP) || (n_etype == ETYPE_RARP);
    assign o_start    = full_frame && etype_ok && (n_tpa == i_own_ip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_etype <= n_etype;
        r_tpa   <= n_tpa;
    end

endmodule

### rtl/arp_tx.sv
// Reply sequencer: walks the 42 reply bytes, reads the header store, drives the output.
// Depends on arp_pkg and arp_stream_if.
module arp_tx
    import arp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_own_ip,
    input  logic [47:0] i_own_mac,
    input  logic [7:0]  i_rd_data,
    output logic        o_busy,
    output logic        o_rd_en,
    output t_pos        o_rd_addr,
    arp_tx_if.source    o_tx
);

    t_tx_state  r_state, n_state;
    t_pos       r_idx;
    logic       r_rd_valid;
    t_src       r_rd_src;
    logic       r_rd_last;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    t_src       cur_src;
    logic       out_free;
    logic       issue;
    logic [7:0] byte_sel;

    assign cur_src  = reply_src(r_idx);
    assign out_free = !r_out_valid || o_tx.ready;
    assign issue    = (r_state == TX_SEND) && (!r_rd_valid || out_free);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            TX_IDLE: if (i_start) n_state = TX_SEND;
            TX_SEND: if (issue && (r_idx == LAST_IDX)) n_state = TX_IDLE;
            default: n_state = TX_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_busy    = 1'b0;
        o_rd_en   = 1'b0;
        o_rd_addr = cur_src.sel;
        case (r_state)
            TX_IDLE: ;
            TX_SEND: begin
                o_busy  = 1'b1;
                o_rd_en = issue;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TX_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the byte index on each issued read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_start) begin
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= r_idx + POS_W'(1);
        end
    end

    // Track the read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (issue) begin
            r_rd_valid <= 1'b1;
        end else if (out_free) begin
            r_rd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_src  <= cur_src;
            r_rd_last <= (r_idx == LAST_IDX);
        end
    end

    // Pick the reply byte from its source
    always_comb begin
        case (r_rd_src.kind)
            SRC_MEM:    byte_sel = i_rd_data;
            SRC_MAC:    byte_sel = mac_byte(i_own_mac, r_rd_src.sel[2:0]);
            SRC_IP:     byte_sel = ip_byte(i_own_ip, r_rd_src.sel[1:0]);
            SRC_ZERO:   byte_sel = 8'h00;
            SRC_OPCODE: byte_sel = OPCODE_REPLY_LO;
            default:    byte_sel = 8'h00;
        endcase
    end

    // Output register: load when free, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_rd_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_tx.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_valid && out_free) begin
            r_out_byte <= byte_sel;
            r_out_last <= r_rd_last;
        end
    end

    assign o_tx.valid      = r_out_valid;
    assign o_tx.reply_byte = r_out_byte;
    assign o_tx.reply_last = r_out_last;

endmodule

### rtl/arp_reply_responder.sv
// ARP reply responder top level: configuration registers, receive side,
// header store and reply sequencer. Depends on arp_pkg, arp_stream_if, arp_hdr_ram,
// arp_rx and arp_tx.
//
//   channel   dir  handshake          payload
//   i_rx      in   valid/ready        data_byte[7:0], frame_end
//   o_tx      out  valid/ready        reply_byte[7:0], reply_last
//   cfg       in   i_cfg_we           i_cfg_idx[1:0], i_cfg_data[47:0]
//
// Frame bytes are taken one per cycle; input is held off while reply reads are
// issued. A matching request starts a reply: the send state is entered, a header
// store read is issued and its byte is loaded into the output register. The 42
// reply bytes then leave one per cycle unless the output stalls, paced by the single
// header store read port. Stalls hold the read pipeline in place; nothing is lost.
// Reset is synchronous; the header store needs no clearing pass.
module arp_reply_responder
    import arp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    arp_rx_if.sink                i_rx,
    arp_tx_if.source              o_tx
);

    logic [31:0] r_own_ip;
    logic [47:0] r_own_mac;
    t_hdr_wr     hdr_wr;
    logic        start;
    logic        busy;
    logic        rd_en;
    t_pos        rd_addr;
    logic [7:0]  rd_data;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= OWN_IP_RST;
            r_own_mac <= OWN_MAC_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OWN_IP:  r_own_ip  <= i_cfg_data[31:0];
                CFG_OWN_MAC: r_own_mac <= i_cfg_data[47:0];
                default:     ;
            endcase
        end
    end

    arp_rx u_rx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_busy   (busy),
        .i_own_ip (r_own_ip),
        .o_wr     (hdr_wr),
        .o_start  (start)
    );

    arp_hdr_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (hdr_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    arp_tx u_tx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_own_ip  (r_own_ip),
        .i_own_mac (r_own_mac),
        .i_rd_data (rd_data),
        .o_busy    (busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_tx      (o_tx)
    );

endmodule
